@@ src/plhas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package plhas_pkg;

  localparam int WordWidth     = 64;
  localparam int LaneNarrow    = 16;
  localparam int LaneWide      = 32;
  localparam int NarrowLanes   = WordWidth / LaneNarrow;
  localparam int WideLanes     = WordWidth / LaneWide;
  localparam int ModeWidth     = 2;
  localparam int CfgIndexWidth = 1;

  localparam logic [WordWidth-1:0] MaskReset = {WordWidth{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [ModeWidth-1:0] {
    MODE_LANE16 = 2'd0,
    MODE_LANE32 = 2'd1,
    MODE_MASKED = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  localparam logic [CfgIndexWidth-1:0] CfgDataMask    = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CfgElementMode = 1'd1;

  typedef struct packed {
    op_t                  operation;
    logic [WordWidth-1:0] word_a;
    logic [WordWidth-1:0] word_b;
    logic                 last_word;
  } in_item_t;

  typedef struct packed {
    logic [WordWidth-1:0] word_out;
    logic                 padding_clean;
    logic                 last_out;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/packed_lane_hash_add_sub.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake            Payload
// --------   ---------  -------------------  --------------------------------------
// in         receive    in_valid / in_stall  in_item_t: operation, word_a, word_b, last
// out        send       out_valid/out_stall  out_item_t: word_out, padding_clean, last
// cfg        receive    cfg_write_enable     cfg_index, cfg_data (no read-back)
//
// Each word passes from its input transfer through the input register and then the
// result register to its output transfer; the lane adders and the mask logic lie
// between the two registers.
// One word can be transferred in every cycle while the output does not stall.
// Reset (rst, synchronous) empties both registers, loads data_mask with all ones,
// element_mode with masked mode and sets the padding flag to clean.
// A stall on the output holds the result register; the input register still
// takes a transfer while it is empty, so in_stall rises only when both are full.

module packed_lane_hash_add_sub (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire plhas_pkg::in_item_t               in_data,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      plhas_pkg::out_item_t              out_data,
  input  wire logic                              cfg_write_enable,
  input  wire logic [plhas_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [plhas_pkg::WordWidth-1:0]   cfg_data
);
  import plhas_pkg::*;

  // Configuration registers.
  logic [WordWidth-1:0] data_mask;
  mode_t                element_mode;

  // Input register stage.
  logic     stage_valid;
  in_item_t stage;

  // Sticky padding flag for the buffer in progress.
  logic clean;

  logic      result_ready;
  logic      stage_ready;
  logic      advance;
  out_item_t result_next;
  logic      clean_next;

  logic [WordWidth-1:0] lane16_sum;
  logic [WordWidth-1:0] lane32_sum;
  logic [WordWidth-1:0] masked_sum;
  logic [WordWidth-1:0] neg_b;
  logic                 is_sub;
  logic                 padding_hit;

  // The result register is free when it is empty or its result is taken now;
  // the input register is free when it is empty or moves on now.
  assign result_ready = !out_valid || !out_stall;
  assign stage_ready  = !stage_valid || result_ready;
  assign advance      = stage_valid && result_ready;
  assign in_stall     = !stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_mask    <= MaskReset;
      element_mode <= MODE_MASKED;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CfgDataMask:    data_mask    <= cfg_data;
        CfgElementMode: element_mode <= mode_t'(cfg_data[ModeWidth-1:0]);
        default:        data_mask    <= data_mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && in_valid) begin
      stage <= in_data;
    end
  end

  // Lane arithmetic: each lane is added or subtracted on its own, so carries
  // and borrows never cross a lane boundary.
  assign is_sub = (stage.operation == OP_SUB);

  always_comb begin
    lane16_sum = '0;
    for (int i = 0; i < NarrowLanes; i++) begin
      lane16_sum[i*LaneNarrow +: LaneNarrow] = is_sub ?
        stage.word_a[i*LaneNarrow +: LaneNarrow] - stage.word_b[i*LaneNarrow +: LaneNarrow] :
        stage.word_a[i*LaneNarrow +: LaneNarrow] + stage.word_b[i*LaneNarrow +: LaneNarrow];
    end
  end

  always_comb begin
    lane32_sum = '0;
    for (int i = 0; i < WideLanes; i++) begin
      lane32_sum[i*LaneWide +: LaneWide] = is_sub ?
        stage.word_a[i*LaneWide +: LaneWide] - stage.word_b[i*LaneWide +: LaneWide] :
        stage.word_a[i*LaneWide +: LaneWide] + stage.word_b[i*LaneWide +: LaneWide];
    end
  end

  // Masked mode subtracts by adding the masked complement of b, so that the
  // padding bits stay zero in the result.
  assign neg_b      = (~data_mask - stage.word_b) & data_mask;
  assign masked_sum = (stage.word_a + (is_sub ? neg_b : stage.word_b)) & data_mask;

  assign padding_hit = ((stage.word_a & ~data_mask) != '0);

  always_comb begin
    result_next = '0;
    clean_next  = clean;
    case (stage.operation)
      OP_ADD, OP_SUB: begin
        case (element_mode)
          MODE_LANE16: result_next.word_out = lane16_sum;
          MODE_LANE32: result_next.word_out = lane32_sum;
          default:     result_next.word_out = masked_sum;
        endcase
      end
      OP_CLEAR: begin
        result_next.word_out = stage.word_a & data_mask;
      end
      OP_CHECK: begin
        result_next.word_out = stage.word_a;
        clean_next           = clean && !padding_hit;
      end
      default: begin
        result_next.word_out = stage.word_a;
      end
    endcase
    result_next.padding_clean = clean_next;
    result_next.last_out      = stage.last_word;
  end

  // The flag returns to clean after the final word of a buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clean <= 1'b1;
    end else if (advance) begin
      clean <= clean_next || stage.last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ src/plhas_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plhas_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire plhas_pkg::out_item_t                out_data,
  input wire logic                                cfg_write_enable
);

  logic in_transfer;
  assign in_transfer = in_valid && !in_stall;

  // A result held back by the receiver stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // The input side stalls only when a result waits and both stages are full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Reset leaves no result on the port.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // With no input transfer and no output stall, the block drains.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!in_transfer && !out_stall) ##1 (!in_transfer && !out_stall) |=> !out_valid)
    else $error("result appeared without an input transfer");

  // Registers are written only while no word is offered and no result waits.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_write_enable |-> !in_valid && !out_valid)
    else $error("register written while words were in flight");

endmodule

bind packed_lane_hash_add_sub plhas_checker u_plhas_checker (.*);

`default_nettype wire

@@ sim/tb_packed_lane_hash_add_sub.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the packed lane add/subtract block. A driver and a
// monitor run as clocked processes; the main sequence only queues words,
// writes registers while the block is idle, and waits for the pipeline to drain.
module tb_packed_lane_hash_add_sub;

  import plhas_pkg::*;

  // The watchdog gives up after this many cycles without any transfer.
  // The longest quiet stretch in a correct run is the long receiver hold-off
  // plus a few register writes, well below this figure.
  localparam int QuietLimit = 2000;

  // The long receiver hold-off starts once this many results have been taken.
  localparam int HoldAt     = 500;
  localparam int HoldCycles = 80;

  localparam int RandomSettings = 8;
  localparam int WordsPerSetting = 135;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } pending_word_t;

  logic clk;
  logic rst = 1'b1;

  logic                     in_valid         = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data          = '0;
  logic                     out_valid;
  logic                     out_stall        = 1'b0;
  out_item_t                out_data;
  logic                     cfg_write_enable = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index        = '0;
  logic [WordWidth-1:0]     cfg_data         = '0;

  // Words waiting to be offered, and results predicted for accepted words.
  pending_word_t pending_words[$];
  out_item_t     expected_words[$];

  // Local copy of the block's registers and its sticky padding flag.
  logic [WordWidth-1:0] model_mask  = MaskReset;
  mode_t                model_mode  = MODE_MASKED;
  logic                 model_clean = 1'b1;

  // Idling switches. The sender's gap is drawn when a word is queued; the
  // receiver draws its stall after every result transfer.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  int unsigned gap_count;
  int unsigned rx_wait;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;

  int unsigned errors        = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 0;
  int unsigned dirty_checks  = 0;
  int unsigned buffers_ended = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  packed_lane_hash_add_sub dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Computes the result of one accepted word and advances the sticky flag.
  // Lane modes wrap each lane on its own; masked mode (and the spare mode,
  // which behaves the same) works on the whole word under the mask. Clear and
  // check padding always use the mask, whatever the mode.
  function automatic out_item_t hash_word_step(in_item_t word);
    out_item_t            res;
    logic [WordWidth-1:0] neg_b;
    bit                   sub;
    sub = (word.operation == OP_SUB);
    res = '0;
    case (word.operation)
      OP_ADD, OP_SUB: begin
        case (model_mode)
          MODE_LANE16: begin
            for (int i = 0; i < NarrowLanes; i++) begin
              res.word_out[i*LaneNarrow +: LaneNarrow] = sub ?
                word.word_a[i*LaneNarrow +: LaneNarrow] - word.word_b[i*LaneNarrow +: LaneNarrow] :
                word.word_a[i*LaneNarrow +: LaneNarrow] + word.word_b[i*LaneNarrow +: LaneNarrow];
            end
          end
          MODE_LANE32: begin
            for (int i = 0; i < WideLanes; i++) begin
              res.word_out[i*LaneWide +: LaneWide] = sub ?
                word.word_a[i*LaneWide +: LaneWide] - word.word_b[i*LaneWide +: LaneWide] :
                word.word_a[i*LaneWide +: LaneWide] + word.word_b[i*LaneWide +: LaneWide];
            end
          end
          default: begin
            if (sub) begin
              // Negate within the element field: the padding bits act as the
              // carry sink, so the difference lands back inside the mask.
              neg_b = (~model_mask - word.word_b) & model_mask;
              res.word_out = (word.word_a + neg_b) & model_mask;
            end else begin
              res.word_out = (word.word_a + word.word_b) & model_mask;
            end
          end
        endcase
      end
      OP_CLEAR: res.word_out = word.word_a & model_mask;
      default: begin
        res.word_out = word.word_a;
        if ((word.word_a & ~model_mask) != '0) begin
          model_clean = 1'b0;
          dirty_checks++;
        end
      end
    endcase
    res.padding_clean = model_clean;
    res.last_out      = word.last_word;
    // The flag is shown for the final word first, then rearmed for the next buffer.
    if (word.last_word) begin
      model_clean = 1'b1;
      buffers_ended++;
    end
    return res;
  endfunction

  // Driver: offers queued words, holding each one until it is taken. A word
  // waits its drawn gap in free cycles before it is offered; a gap of zero
  // keeps in_valid high straight through for back-to-back transfers.
  always @(posedge clk) begin
    logic free;
    if (rst) begin
      in_valid <= 1'b0;
      gap_count = 0;
    end else begin
      free = !in_valid;
      if (in_fire) begin
        expected_words.push_back(hash_word_step(in_data));
        words_sent++;
        free = 1'b1;
      end
      if (free) begin
        if (pending_words.size() != 0 && gap_count >= pending_words[0].gap) begin
          in_data  <= pending_words[0].item;
          in_valid <= 1'b1;
          pending_words.pop_front();
          gap_count = 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_words.size() != 0) begin
            gap_count++;
          end
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest prediction and
  // drives the receiver stall from its own per-result draw and the hold-off.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_fire) begin
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected result: word_out %h padding_clean %b last_out %b",
                 out_data.word_out, out_data.padding_clean, out_data.last_out);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.word_out !== want.word_out) begin
            $error("word_out: expected %h, got %h", want.word_out, out_data.word_out);
            errors++;
          end
          if (out_data.padding_clean !== want.padding_clean) begin
            $error("padding_clean: expected %b, got %b",
                   want.padding_clean, out_data.padding_clean);
            errors++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, out_data.last_out);
            errors++;
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  // One long receiver hold-off partway through the random part. The sender
  // keeps offering words meanwhile, so both pipeline registers fill and the
  // block has to raise in_stall.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog on progress: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("tb_packed_lane_hash_add_sub: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; only called while nothing is in flight, so the local copy
  // can follow at once.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                           input logic [WordWidth-1:0] value);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= index;
    cfg_data         <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    if (index == CfgDataMask) begin
      model_mask = value;
    end else begin
      model_mode = mode_t'(value[ModeWidth-1:0]);
    end
  endtask

  // Writes both registers and sets the idling for the next batch of words.
  // The mode goes in with random upper bits, which the block must ignore.
  task automatic apply_setting(input logic [WordWidth-1:0] mask, input mode_t mode,
                               input bit idle);
    logic [WordWidth-1:0] mode_word;
    mode_word = {$urandom, $urandom};
    mode_word[ModeWidth-1:0] = mode;
    write_reg(CfgDataMask, mask);
    write_reg(CfgElementMode, mode_word);
    @(negedge clk);
    tx_idle = idle;
    rx_idle <= idle;
    settings_used++;
  endtask

  task automatic queue_word(input op_t op, input logic [WordWidth-1:0] a,
                            input logic [WordWidth-1:0] b, input logic last);
    pending_word_t p;
    p.item.operation = op;
    p.item.word_a    = a;
    p.item.word_b    = b;
    p.item.last_word = last;
    p.gap            = tx_idle ? $urandom_range(0, 9) : 0;
    pending_words.push_back(p);
  endtask

  // Operands lean on values that make lanes or masked words wrap.
  function automatic logic [WordWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_8000_8000_8000;
      3:       return 64'h0001_0001_0001_0001;
      4:       return 64'h7fff_ffff_7fff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Masks in the shape of packed elements with padding bits, plus the edges.
  function automatic logic [WordWidth-1:0] pick_mask();
    case ($urandom_range(0, 6))
      0:       return '1;
      1:       return '0;
      2:       return 64'h7fff_7fff_7fff_7fff;
      3:       return 64'h3fff_ffff_3fff_ffff;
      4:       return 64'h000f_ffff_ffff_ffff;
      5:       return 64'h0fff_0fff_0fff_0fff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Queues one buffer. Most buffers are well formed: one operation throughout
  // and last set on the final word only. Check buffers are mostly clean so the
  // sticky flag survives to the end; some carry a stray padding bit. About one
  // buffer in five is noise with mixed operations and random last marks.
  task automatic queue_buffer(inout int unsigned queued);
    int unsigned          len;
    bit                   mixed;
    bit                   dirty_buf;
    op_t                  op;
    logic [WordWidth-1:0] a;
    logic                 last;
    len       = $urandom_range(1, 8);
    mixed     = ($urandom_range(0, 4) == 0);
    dirty_buf = ($urandom_range(0, 2) == 0);
    op        = op_t'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      if (mixed) begin
        op = op_t'($urandom_range(0, 3));
      end
      a = pick_operand();
      if ((op == OP_CHECK || op == OP_CLEAR) && !(dirty_buf && $urandom_range(0, 2) == 0)) begin
        a = a & model_mask;
      end
      last = mixed ? logic'($urandom_range(0, 1)) : (i == len - 1);
      queue_word(op, a, pick_operand(), last);
      queued++;
    end
  endtask

  // Waits until every queued word has gone in and every result has come out,
  // then lets the two pipeline stages settle before anything else happens.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned queued;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: full mask in masked mode, so no padding exists at all.
    queue_word(OP_ADD,   '1, 64'd1, 1'b0);
    queue_word(OP_SUB,   '0, 64'd1, 1'b0);
    queue_word(OP_CLEAR, '1, '0,    1'b0);
    queue_word(OP_CHECK, '1, '0,    1'b1);
    drain();

    // Packed 15-bit elements: wrap into the padding bit, then the sticky flag
    // is cleared by a stray padding bit, held by other operations, shown on the
    // final word and rearmed for the next buffer.
    apply_setting(64'h7fff_7fff_7fff_7fff, MODE_MASKED, 1'b1);
    queue_word(OP_ADD,   64'h7fff_7fff_7fff_7fff, 64'h0001_0001_0001_0001, 1'b0);
    queue_word(OP_SUB,   64'h0000_0000_0000_0000, 64'h0001_0001_0001_0001, 1'b0);
    queue_word(OP_CLEAR, '1,                      '1,                      1'b0);
    queue_word(OP_CHECK, 64'h1234_0567_7fff_0000, '0,                      1'b0);
    queue_word(OP_CHECK, 64'h8000_0000_0000_0000, '0,                      1'b0);
    queue_word(OP_ADD,   64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002, 1'b0);
    queue_word(OP_CHECK, 64'h0000_0000_0000_0001, '0,                      1'b1);
    queue_word(OP_CLEAR, 64'h8000_8000_8000_8000, '0,                      1'b0);
    drain();

    // Spare mode must act as masked mode; an empty mask makes everything padding.
    apply_setting('0, MODE_SPARE, 1'b1);
    queue_word(OP_ADD,   '1,     '1,    1'b0);
    queue_word(OP_SUB,   '1,     64'd5, 1'b0);
    queue_word(OP_CHECK, 64'd1,  '0,    1'b1);
    drain();

    // Sixteen-bit lanes: each lane wraps alone and the mask plays no part in
    // add or subtract, while clear and check still use it on the whole word.
    apply_setting(64'h00ff_00ff_00ff_00ff, MODE_LANE16, 1'b1);
    queue_word(OP_ADD,   '1,                      64'h0001_0001_0001_0001, 1'b0);
    queue_word(OP_SUB,   '0,                      64'h0001_0001_0001_0001, 1'b0);
    queue_word(OP_CLEAR, '1,                      '1,                      1'b0);
    queue_word(OP_CHECK, 64'h0100_0000_0000_0000, '0,                      1'b1);
    drain();

    // Thirty-two-bit lanes.
    apply_setting({$urandom, $urandom}, MODE_LANE32, 1'b1);
    queue_word(OP_ADD, '1,                      64'h0000_0001_0000_0001, 1'b0);
    queue_word(OP_SUB, 64'h8000_0000_0000_0000, 64'h0000_0001_0000_0001, 1'b0);
    queue_word(OP_ADD, 64'h7fff_ffff_7fff_ffff, 64'h0000_0001_0000_0001, 1'b1);
    drain();

    // Random part: every mode in turn under a fresh mask. Every third setting
    // runs with no idling on either side.
    for (int s = 0; s < RandomSettings; s++) begin
      apply_setting(pick_mask(), mode_t'(s % 4), (s % 3) != 2);
      queued = 0;
      while (queued < WordsPerSetting) begin
        queue_buffer(queued);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected results never arrived", expected_words.size());
      errors++;
    end

    $display("Covered %0d words and %0d results over %0d register settings,",
             words_sent, results_seen, settings_used + 1);
    $display("with %0d buffer ends and %0d padding checks that found a stray bit.",
             buffers_ended, dirty_checks);
    if (errors == 0) begin
      $display("tb_packed_lane_hash_add_sub: PASS");
    end else begin
      $display("tb_packed_lane_hash_add_sub: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/plhas_pkg.sv
src/packed_lane_hash_add_sub.sv
src/plhas_checker.sv
sim/tb_packed_lane_hash_add_sub.sv
